// ===== src/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 message hasher package
// Types, constants and round functions shared by the hasher modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sha256_pkg;

	localparam int unsigned WORD_W        = 32;
	localparam int unsigned ROUNDS        = 64;
	localparam int unsigned ROUND_W       = $clog2(ROUNDS);
	localparam int unsigned HASH_WORDS    = 8;
	localparam int unsigned WORDS_PER_BLK = 16;
	localparam int unsigned IDX_W         = $clog2(WORDS_PER_BLK);
	localparam int unsigned COUNT_W       = 30;
	localparam int unsigned OUT_CNT_W     = $clog2(HASH_WORDS + 1);

	localparam logic [31:0] BYTES_RESET = 32'd96;
	localparam logic        REG_MSG_LEN = 1'b0;
	localparam logic [7:0]  PAD_MARK    = 8'h80;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [HASH_WORDS-1:0][WORD_W-1:0] hash_t;

	typedef enum logic [2:0] {
		SEL_INPUT,
		SEL_TAIL,
		SEL_MARK,
		SEL_ZERO,
		SEL_LEN_HI,
		SEL_LEN_LO
	} word_sel_t;

	typedef struct packed {
		logic               put;
		word_sel_t          sel;
		logic               load_work;
		logic               round;
		logic [ROUND_W-1:0] round_idx;
		logic               add;
		logic               finish;
		logic               restart;
	} dp_cmd_t;

	function automatic word_t iv_word(input logic [2:0] i);
		word_t w;
		case (i)
			3'd0:    w = 32'h6a09e667;
			3'd1:    w = 32'hbb67ae85;
			3'd2:    w = 32'h3c6ef372;
			3'd3:    w = 32'ha54ff53a;
			3'd4:    w = 32'h510e527f;
			3'd5:    w = 32'h9b05688c;
			3'd6:    w = 32'h1f83d9ab;
			3'd7:    w = 32'h5be0cd19;
			default: w = 32'h0;
		endcase
		return w;
	endfunction

	function automatic word_t k_const(input logic [ROUND_W-1:0] t);
		word_t k;
		case (t)
			6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	function automatic word_t bsig0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t bsig1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t ssig0(input word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'd0, x[31:3]};
	endfunction

	function automatic word_t ssig1(input word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

	function automatic word_t choose(input word_t e, input word_t f, input word_t g);
		return g ^ (e & (f ^ g));
	endfunction

	function automatic word_t majority(input word_t a, input word_t b, input word_t c);
		return (a & b) ^ (c & (a ^ b));
	endfunction

endpackage

`default_nettype wire

// ===== src/sha256_dp.sv =====
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Message schedule window, working variables, round logic and chaining hash.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sha256_pkg::dp_cmd_t cmd,
	input  wire sha256_pkg::word_t   message_word,
	input  wire logic [31:0]         msg_len,
	output sha256_pkg::hash_t        digest_sum
);
	import sha256_pkg::*;

	word_t win_q [WORDS_PER_BLK];
	hash_t work_q;
	hash_t chain_q;
	word_t put_word;
	word_t sched_next;
	word_t t1;
	word_t t2;

	always_comb begin
		case (cmd.sel)
			SEL_INPUT: put_word = message_word;
			SEL_TAIL: begin
				case (msg_len[1:0])
					2'd1:    put_word = {message_word[31:24], PAD_MARK, 16'd0};
					2'd2:    put_word = {message_word[31:16], PAD_MARK, 8'd0};
					2'd3:    put_word = {message_word[31:8], PAD_MARK};
					default: put_word = message_word;
				endcase
			end
			SEL_MARK:   put_word = {PAD_MARK, 24'd0};
			SEL_ZERO:   put_word = '0;
			SEL_LEN_HI: put_word = {29'd0, msg_len[31:29]};
			SEL_LEN_LO: put_word = {msg_len[28:0], 3'd0};
			default:    put_word = '0;
		endcase
	end

	assign sched_next = ssig1(win_q[14]) + win_q[9] + ssig0(win_q[1]) + win_q[0];
	assign t1 = work_q[7] + bsig1(work_q[4]) + choose(work_q[4], work_q[5], work_q[6])
	          + k_const(cmd.round_idx) + win_q[0];
	assign t2 = bsig0(work_q[0]) + majority(work_q[0], work_q[1], work_q[2]);

	always_comb begin
		for (int i = 0; i < HASH_WORDS; i++) begin
			digest_sum[i] = chain_q[i] + work_q[i];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.put || cmd.round) begin
			for (int i = 0; i < WORDS_PER_BLK - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[WORDS_PER_BLK-1] <= cmd.put ? put_word : sched_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_work) begin
			work_q <= chain_q;
		end else if (cmd.round) begin
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HASH_WORDS; i++) begin
				chain_q[i] <= iv_word(3'(i));
			end
		end else if (cmd.restart || cmd.finish) begin
			for (int i = 0; i < HASH_WORDS; i++) begin
				chain_q[i] <= iv_word(3'(i));
			end
		end else if (cmd.add) begin
			chain_q <= digest_sum;
		end
	end

endmodule

`default_nettype wire

// ===== src/sha256_out.sv =====
// ----------------------------------------------------------------------------
// SHA-256 digest output buffer
// Holds a finished digest and hands it out one word per request.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_out (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire sha256_pkg::hash_t digest_sum,
	output sha256_pkg::word_t      digest_word,
	output logic                   digest_last,
	output logic                   digest_valid,
	input  wire logic              digest_ready,
	output logic                   busy
);
	import sha256_pkg::*;

	hash_t                digest_q;
	logic [OUT_CNT_W-1:0] count_q;

	assign busy         = (count_q != '0);
	assign digest_valid = busy;
	assign digest_word  = digest_q[0];
	assign digest_last  = (count_q == OUT_CNT_W'(1));

	always_ff @(posedge clk) begin
		if (load) begin
			digest_q <= digest_sum;
		end else if (digest_valid && digest_ready) begin
			digest_q <= digest_q >> WORD_W;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (load) begin
			count_q <= OUT_CNT_W'(HASH_WORDS);
		end else if (digest_valid && digest_ready) begin
			count_q <= count_q - OUT_CNT_W'(1);
		end
	end

endmodule

`default_nettype wire

// ===== src/sha256_ctrl.sv =====
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences word intake, padding, the compression rounds and the final add.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          message_valid,
	output logic               message_ready,
	input  wire logic [31:0]   msg_len,
	input  wire logic          cfg_write,
	input  wire logic          out_busy,
	output sha256_pkg::dp_cmd_t cmd
);
	import sha256_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_PAD   = 4'b0010,
		S_ROUND = 4'b0100,
		S_ADD   = 4'b1000
	} state_t;

	typedef enum logic [3:0] {
		STEP_MARK   = 4'b0001,
		STEP_ZERO   = 4'b0010,
		STEP_LEN_LO = 4'b0100,
		STEP_DONE   = 4'b1000
	} pad_step_t;

	localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(WORDS_PER_BLK - 1);
	localparam logic [IDX_W-1:0]   LEN_IDX    = IDX_W'(WORDS_PER_BLK - 2);
	localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);

	state_t               state_q, state_d;
	pad_step_t            step_q, step_d;
	logic                 padding_q, padding_d;
	logic [COUNT_W-1:0]   words_q, words_d;
	logic [IDX_W-1:0]     idx_q, idx_d;
	logic [ROUND_W-1:0]   round_q, round_d;
	logic [COUNT_W:0]     total_words;
	logic [COUNT_W:0]     words_next;
	logic                 final_word;
	logic                 accept;

	assign message_ready = (state_q == S_IDLE);
	assign accept        = message_valid && message_ready;
	assign total_words   = {1'b0, msg_len[31:2]} + (COUNT_W+1)'(msg_len[1:0] != 2'd0);
	assign words_next    = {1'b0, words_q} + (COUNT_W+1)'(1);
	assign final_word    = (words_next >= total_words);

	always_comb begin
		cmd           = '0;
		cmd.sel       = SEL_ZERO;
		cmd.round_idx = round_q;
		state_d       = state_q;
		step_d        = step_q;
		padding_d     = padding_q;
		words_d       = words_q;
		idx_d         = idx_q;
		round_d       = round_q;
		case (state_q)
			S_IDLE: begin
				if (accept && (msg_len != '0)) begin
					cmd.put = 1'b1;
					idx_d   = idx_q + IDX_W'(1);
					if (final_word) begin
						cmd.sel   = SEL_TAIL;
						padding_d = 1'b1;
						step_d    = (msg_len[1:0] == 2'd0) ? STEP_MARK : STEP_ZERO;
						state_d   = S_PAD;
					end else begin
						cmd.sel = SEL_INPUT;
						words_d = words_next[COUNT_W-1:0];
					end
					if (idx_q == LAST_IDX) begin
						cmd.load_work = 1'b1;
						round_d       = '0;
						state_d       = S_ROUND;
					end
				end
			end
			S_PAD: begin
				cmd.put = 1'b1;
				idx_d   = idx_q + IDX_W'(1);
				case (step_q)
					STEP_MARK: begin
						cmd.sel = SEL_MARK;
						step_d  = STEP_ZERO;
					end
					STEP_ZERO: begin
						if (idx_q == LEN_IDX) begin
							cmd.sel = SEL_LEN_HI;
							step_d  = STEP_LEN_LO;
						end else begin
							cmd.sel = SEL_ZERO;
						end
					end
					STEP_LEN_LO: begin
						cmd.sel = SEL_LEN_LO;
						step_d  = STEP_DONE;
					end
					default: begin
						cmd.put = 1'b0;
						idx_d   = idx_q;
					end
				endcase
				if (cmd.put && (idx_q == LAST_IDX)) begin
					cmd.load_work = 1'b1;
					round_d       = '0;
					state_d       = S_ROUND;
				end
			end
			S_ROUND: begin
				cmd.round = 1'b1;
				round_d   = round_q + ROUND_W'(1);
				if (round_q == LAST_ROUND) begin
					state_d = S_ADD;
				end
			end
			S_ADD: begin
				if (padding_q && (step_q == STEP_DONE)) begin
					if (!out_busy) begin
						cmd.add    = 1'b1;
						cmd.finish = 1'b1;
						padding_d  = 1'b0;
						step_d     = STEP_MARK;
						words_d    = '0;
						idx_d      = '0;
						state_d    = S_IDLE;
					end
				end else if (padding_q) begin
					cmd.add = 1'b1;
					state_d = S_PAD;
				end else begin
					cmd.add = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (cfg_write) begin
			cmd.restart = 1'b1;
			words_d     = '0;
			idx_d       = '0;
			padding_d   = 1'b0;
			step_d      = STEP_MARK;
			state_d     = S_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			step_q    <= STEP_MARK;
			padding_q <= 1'b0;
			words_q   <= '0;
			idx_q     <= '0;
			round_q   <= '0;
		end else begin
			state_q   <= state_d;
			step_q    <= step_d;
			padding_q <= padding_d;
			words_q   <= words_d;
			idx_q     <= idx_d;
			round_q   <= round_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/sha256_message_hasher.sv =====
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Hashes fixed-length messages of 32-bit words and returns the 8-word digest.
// ----------------------------------------------------------------------------
//  Channel   Signals                                   Moves
//  message   message_valid/ready, message_word         one message word per request
//  digest    digest_valid/ready, digest_word, _last    one digest word per request
//  config    psel, penable, pwrite, paddr, pwdata      message length register
//
//  Message words are taken while the controller is idle; the sixteenth word of a
//  block starts the 64 compression rounds and then the add into the chaining hash.
//  The final word is followed by the padding words and one or two compressions.
//  The digest sits in an output buffer, so the next message is taken while it
//  drains; a later digest waits in the add cycle until the buffer is empty.
//  Reset restores the initial hash values at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_message_hasher (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [31:0] message_word,
	input  wire logic        message_valid,
	output logic             message_ready,
	output logic [31:0]      digest_word,
	output logic             digest_last,
	output logic             digest_valid,
	input  wire logic        digest_ready,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import sha256_pkg::*;

	logic [31:0] bytes_q;
	logic        cfg_write;
	logic        out_busy;
	dp_cmd_t     cmd;
	hash_t       digest_sum;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_MSG_LEN);
	assign prdata    = (paddr[2] == REG_MSG_LEN) ? bytes_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q <= BYTES_RESET;
		end else if (cfg_write) begin
			bytes_q <= pwdata;
		end
	end

	sha256_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.message_valid (message_valid),
		.message_ready (message_ready),
		.msg_len       (bytes_q),
		.cfg_write     (cfg_write),
		.out_busy      (out_busy),
		.cmd           (cmd)
	);

	sha256_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.message_word  (message_word),
		.msg_len       (bytes_q),
		.digest_sum    (digest_sum)
	);

	sha256_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (cmd.finish),
		.digest_sum   (digest_sum),
		.digest_word  (digest_word),
		.digest_last  (digest_last),
		.digest_valid (digest_valid),
		.digest_ready (digest_ready),
		.busy         (out_busy)
	);

endmodule

`default_nettype wire

// ===== src/sha256_checker.sv =====
// ----------------------------------------------------------------------------
// SHA-256 message hasher checker
// Port-level checks on the digest channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic [31:0] digest_word,
	input wire logic        digest_last,
	input wire logic        digest_valid,
	input wire logic        digest_ready
);

	a_digest_hold: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && !digest_ready |=> digest_valid && $stable(digest_word)
		&& $stable(digest_last))
	else $error("digest request changed while stalled");

	a_last_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!digest_valid |-> !digest_last)
	else $error("digest_last raised without a digest request");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && digest_ready && digest_last |=> !digest_valid)
	else $error("digest request directly after the last word");

	a_words_follow: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && digest_ready && !digest_last |=> digest_valid)
	else $error("digest ended before its eighth word");

endmodule

bind sha256_message_hasher sha256_checker u_sha256_checker (.*);

`default_nettype wire
